### src/arld_pkg.sv
// arld_pkg: shared types and constants for the ACK retain-list decoder.
// Used by arld_front, arld_queue, arld_back and the top level.
// No dependencies.
`default_nettype none

package arld_pkg;

  // ACK byte coding
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MapBit    = 7;   // bitmap byte
  localparam int unsigned LongBit   = 6;   // long offset prefix
  localparam int unsigned LongW     = 6;   // payload bits of a long prefix
  localparam int unsigned LongShift = 8;   // long payload weight (x256)
  localparam int unsigned MapW      = 7;   // request bits in a bitmap byte
  localparam int unsigned MapStep   = 7;   // running number advance per bitmap

  localparam int unsigned NumW      = 32;  // block number width
  localparam int unsigned SpanW     = 16;
  localparam logic [SpanW-1:0] SpanReset = 16'd1024;

  // decoupling queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one queued job: emit base+i+1 for every set bit i of mask
  typedef struct packed {
    logic [NumW-1:0] base;
    logic [MapW-1:0] mask;
  } job_t;

  // front -> queue push
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // queue -> back head view
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

`default_nettype wire

### src/arld_front.sv
// arld_front: accepts ACK words, keeps the running block number and the
// long-prefix flag, and turns each byte into a job for the queue.
// Depends on arld_pkg.
`default_nettype none

module arld_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // span register write
  input  wire logic                      cfg_valid_i,
  input  wire logic [arld_pkg::SpanW-1:0] cfg_data_i,
  // input word
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic                      start_req_i,
  input  wire logic [arld_pkg::NumW-1:0] last_sent_i,
  input  wire logic [arld_pkg::ByteW-1:0] ack_byte_i,
  // queue side
  input  wire logic                      q_full_i,
  output      arld_pkg::push_t           push_o
);

  logic [arld_pkg::SpanW-1:0] span_q;

  // input stage
  logic                        a_valid_q;
  logic                        a_start_q;
  logic [arld_pkg::ByteW-1:0]  a_byte_q;
  logic [arld_pkg::NumW-1:0]   a_reload_q;

  // decode state
  logic [arld_pkg::NumW-1:0]   run_q, run_d;
  logic                        long_q, long_d;

  logic                        a_load, a_go;
  logic [arld_pkg::NumW:0]     diff;
  logic [arld_pkg::NumW-1:0]   reload;
  logic                        lp_eff, is_map, is_long, is_single, produce;
  logic [arld_pkg::NumW-1:0]   base, addend, sum;

  // reload value: last_sent - span, floored at zero
  assign diff   = {1'b0, last_sent_i} - {{(arld_pkg::NumW + 1 - arld_pkg::SpanW){1'b0}}, span_q};
  assign reload = diff[arld_pkg::NumW] ? '0 : diff[arld_pkg::NumW-1:0];

  // classify the held byte
  assign lp_eff    = long_q && !a_start_q;
  assign is_map    = !lp_eff && a_byte_q[arld_pkg::MapBit];
  assign is_long   = !lp_eff && !a_byte_q[arld_pkg::MapBit] && a_byte_q[arld_pkg::LongBit];
  assign is_single = !is_map && !is_long;
  assign produce   = is_single || (is_map && (a_byte_q[arld_pkg::MapW-1:0] != '0));

  assign base = a_start_q ? a_reload_q : run_q;

  always_comb begin
    if (is_map) begin
      addend = arld_pkg::NumW'(arld_pkg::MapStep);
    end else if (is_long) begin
      addend = arld_pkg::NumW'({a_byte_q[arld_pkg::LongW-1:0],
                                {arld_pkg::LongShift{1'b0}}});
    end else begin
      addend = arld_pkg::NumW'(a_byte_q);
    end
  end

  assign sum    = base + addend;
  assign run_d  = is_single ? sum + arld_pkg::NumW'(1) : sum;
  assign long_d = is_long;

  assign a_go       = a_valid_q && (!produce || !q_full_i);
  assign in_ready_o = !a_valid_q || a_go;
  assign a_load     = in_valid_i && in_ready_o;

  // job for the back end
  always_comb begin
    push_o.valid    = a_valid_q && produce && !q_full_i;
    push_o.job.base = is_single ? sum : base;
    push_o.job.mask = is_single ? arld_pkg::MapW'(1) : a_byte_q[arld_pkg::MapW-1:0];
  end

  // span register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= arld_pkg::SpanReset;
    end else if (cfg_valid_i) begin
      span_q <= cfg_data_i;
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_load) begin
      a_valid_q <= 1'b1;
    end else if (a_go) begin
      a_valid_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_start_q  <= start_req_i;
      a_byte_q   <= ack_byte_i;
      a_reload_q <= reload;
    end
  end

  // running number and long-prefix flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      long_q <= 1'b0;
    end else if (a_go) begin
      run_q  <= run_d;
      long_q <= long_d;
    end
  end

endmodule

`default_nettype wire

### src/arld_queue.sv
// arld_queue: short FIFO of jobs between front and back.
// Depends on arld_pkg.
`default_nettype none

module arld_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire arld_pkg::push_t push_i,
  output      logic            full_o,
  output      arld_pkg::head_t head_o,
  input  wire logic            pop_i
);

  arld_pkg::job_t                 mem_q [arld_pkg::QDepth];
  logic [arld_pkg::QPtrW-1:0]     wptr_q, rptr_q;
  logic [arld_pkg::QCntW-1:0]     cnt_q;

  assign full_o         = (cnt_q == arld_pkg::QCntW'(arld_pkg::QDepth));
  assign head_o.valid   = (cnt_q != '0);
  assign head_o.job     = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wptr_q] <= push_i.job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= wptr_q + arld_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + arld_pkg::QPtrW'(1);
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + arld_pkg::QCntW'(1);
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - arld_pkg::QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/arld_back.sv
// arld_back: expands queued jobs into block numbers, one word per cycle while
// the output is not stalled, through a registered output stage.
// Depends on arld_pkg.
`default_nettype none

module arld_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire arld_pkg::head_t            head_i,
  output      logic                       pop_o,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [arld_pkg::NumW-1:0]  block_number_o,
  output      logic                       last_of_run_o
);

  localparam int unsigned IdxW = $clog2(arld_pkg::MapW);

  logic [arld_pkg::NumW-1:0] cur_base_q;
  logic [arld_pkg::MapW-1:0] cur_mask_q;
  logic                      out_valid_q;
  logic [arld_pkg::NumW-1:0] out_num_q;
  logic                      out_last_q;

  logic                      adv, fire, busy;
  logic [IdxW-1:0]           idx;
  logic [arld_pkg::MapW-1:0] rem;

  // lowest set request bit
  always_comb begin
    idx = '0;
    for (int i = arld_pkg::MapW - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        idx = IdxW'(i);
      end
    end
  end

  assign rem   = cur_mask_q & (cur_mask_q - arld_pkg::MapW'(1));
  assign busy  = (cur_mask_q != '0);
  assign adv   = !out_valid_q || out_ready_i;
  assign fire  = adv && busy;
  assign pop_o = head_i.valid && (!busy || (fire && rem == '0));

  // current job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mask_q <= '0;
    end else if (pop_o) begin
      cur_mask_q <= head_i.job.mask;
    end else if (fire) begin
      cur_mask_q <= rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_base_q <= head_i.job.base;
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_num_q  <= cur_base_q + arld_pkg::NumW'(idx) + arld_pkg::NumW'(1);
      out_last_q <= (rem == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_num_q;
  assign last_of_run_o  = out_last_q;

endmodule

`default_nettype wire

### src/ack_retain_list_decoder.sv
// ack_retain_list_decoder: top level, front end, job queue and back end.
// Depends on arld_pkg, arld_front, arld_queue, arld_back.
//
//   channel   dir  handshake                 contents
//   s_axis    in   s_axis_tvalid/tready      tdata: last_sent, ack_byte; tuser: start_req
//   m_axis    out  m_axis_tvalid/tready      tdata: block_number; tlast: last_of_run
//   cfg       in   cfg_valid/cfg_ready       cfg_data: block_span
//
// One ACK byte is taken per cycle while the four-entry job queue has room.
// The back end emits one block number per cycle while the output is ready,
// so a bitmap byte costs up to seven output words; that single-number-per-cycle
// expander sets the sustained rate. A result word passes the input stage, the
// job queue, the current-job register and the output register.
// Reset is asynchronous, active low; span resets to 1024, no clearing pass.
// Either side may stall; the queue and the output register absorb it.
`default_nettype none

module ack_retain_list_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,      // block_span
  // input words
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [31:0] last_sent, [39:32] ack_byte
  input  wire logic [0:0]  s_axis_tuser_i,  // [0] start_req
  // output words
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [31:0] m_axis_tdata_o,  // [31:0] block_number
  output      logic        m_axis_tlast_o   // last_of_run
);

  arld_pkg::push_t push;
  arld_pkg::head_t head;
  logic            q_full;
  logic            pop;

  assign cfg_ready_o = 1'b1;

  arld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .start_req_i (s_axis_tuser_i[0]),
    .last_sent_i (s_axis_tdata_i[31:0]),
    .ack_byte_i  (s_axis_tdata_i[39:32]),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  arld_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  arld_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .block_number_o (m_axis_tdata_o),
    .last_of_run_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

### src/arld_checker.sv
// arld_checker: port-level assertions for ack_retain_list_decoder, and the
// bind that attaches them. Depends on the top level's ports only.
`default_nettype none

module arld_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_ready_o,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // the span register never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // nothing comes out right after reset without input
  a_no_spurious: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output word right after reset");

  // the input side is free after reset, whatever the output side does
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_o)
    else $error("input not ready after reset");

  // straight after reset, with no input offered, no output word follows
  a_no_word_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) && !s_axis_tvalid_i |=> !m_axis_tvalid_o)
    else $error("output word without accepted input");

endmodule

bind ack_retain_list_decoder arld_checker u_arld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_ready_o     (cfg_ready_o),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

### verif/tb.sv
// tb: self-checking bench for ack_retain_list_decoder; drives ACK bytes and span writes,
// predicts the requested block numbers and checks every output word in order.
// Depends on arld_pkg and the ack_retain_list_decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SettleCycles  = 16;    // drain margin past the last result
  localparam int unsigned StallLimit    = 2000;  // cycles without any handshake
  localparam int unsigned BytesPerPhase = 66;

  typedef struct {
    logic [arld_pkg::NumW-1:0] num;
    logic                      last;
  } block_req_t;

  // predicted decoder state and the block numbers still owed by the DUT
  class retain_list_board;
    logic [arld_pkg::SpanW-1:0] span;
    logic [arld_pkg::NumW-1:0]  running;
    bit                         offset_open;
    block_req_t                 wanted[$];
    int unsigned                errors;

    function new();
      span        = arld_pkg::SpanReset;
      running     = '0;
      offset_open = 1'b0;
      errors      = 0;
    endfunction

    function void set_span(logic [arld_pkg::SpanW-1:0] v);
      span = v;
    endfunction

    function void want(logic last);
      block_req_t r;
      r.num  = running;
      r.last = last;
      wanted.push_back(r);
    endfunction

    // decode one accepted ACK byte into the block numbers it requests
    function void take_ack_byte(bit start, logic [arld_pkg::NumW-1:0] last_sent,
                                logic [arld_pkg::ByteW-1:0] b);
      int k;
      if (start) begin
        running     = (last_sent < arld_pkg::NumW'(span)) ? '0
                                                          : last_sent - arld_pkg::NumW'(span);
        offset_open = 1'b0;
      end
      if (offset_open) begin
        // second half of a long offset, whatever its flag bits say
        offset_open = 1'b0;
        running     = running + arld_pkg::NumW'(b) + 1;
        want(1'b1);
      end else if (b[arld_pkg::MapBit]) begin
        for (k = 0; k < arld_pkg::MapW; k++) begin
          running = running + 1;
          if (b[k]) want((b[arld_pkg::MapW-1:0] >> (k + 1)) == '0);
        end
      end else if (b[arld_pkg::LongBit]) begin
        running     = running + (arld_pkg::NumW'(b[arld_pkg::LongW-1:0]) << arld_pkg::LongShift);
        offset_open = 1'b1;
      end else begin
        running = running + arld_pkg::NumW'(b) + 1;
        want(1'b1);
      end
    endfunction

    // compare one output word with the oldest owed block number
    function void check_block(logic [arld_pkg::NumW-1:0] num, logic last);
      block_req_t r;
      if (wanted.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got block %h last %b",
                 $time, num, last);
      end else begin
        r = wanted.pop_front();
        if (num !== r.num) begin
          errors++;
          $display("%0t: block number expected %h, got %h", $time, r.num, num);
        end
        if (last !== r.last) begin
          errors++;
          $display("%0t: last_of_run for block %h expected %b, got %b",
                   $time, r.num, r.last, last);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        s_valid   = 1'b0;
  logic [39:0] s_data    = '0;   // [31:0] last_sent, [39:32] ack_byte
  logic [0:0]  s_user    = '0;   // [0] start_req
  logic        m_ready   = 1'b0;
  wire         cfg_ready;
  wire         s_ready;
  wire         m_valid;
  wire  [31:0] m_data;           // [31:0] block_number
  wire         m_last;

  int unsigned send_idle = 12;
  int unsigned recv_idle = 81;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  retain_list_board board;

  ack_retain_list_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // output check
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) board.check_block(m_data, m_last);
  end

  // watchdog: no handshake of any kind for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one input word, with random gaps in front; returns at the accepting edge
  task automatic send_word(input bit start, input logic [31:0] last_sent,
                           input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      @(negedge clk);
      s_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_data  <= {b, last_sent};
    s_user  <= start;
    do @(posedge clk); while (!s_ready);
    board.take_ack_byte(start, last_sent, b);
    bytes_sent++;
  endtask

  // hold the sender until every owed block has come out, then let the DUT settle
  task automatic wait_drained();
    @(negedge clk);
    s_valid <= 1'b0;
    while (board.wanted.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_span(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_span(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_ack_byte();
    int unsigned roll;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    v    = $urandom;
    if (roll < 35)      return {1'b1, v[6:0]};        // bitmap
    else if (roll < 40) return 8'h80;                 // empty bitmap
    else if (roll < 70) return {2'b00, v[5:0]};       // short offset
    else if (roll < 90) return {2'b01, v[5:0]};       // long prefix
    else                return v[7:0];
  endfunction

  function automatic logic [31:0] pick_last_sent();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      return $urandom;
    else if (roll < 80) return $urandom_range(0, 70000);
    else                return 32'hFFFF_FFFF - $urandom_range(0, 300);
  endfunction

  // one ACK: a start word then up to seven more bytes; without start it just continues
  task automatic send_ack(input bit with_start);
    int unsigned n;
    int unsigned k;
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) send_word(with_start && k == 0, pick_last_sent(), pick_ack_byte());
  endtask

  task automatic run_phase(input int unsigned sidle, input int unsigned ridle,
                           input logic [15:0] span);
    int unsigned first;
    int unsigned acks;
    send_idle = sidle;
    recv_idle = ridle;
    wait_drained();
    write_span(span);
    first = bytes_sent;
    acks  = 0;
    while (bytes_sent - first < BytesPerPhase) begin
      if (acks == 4) wait_drained();
      send_ack($urandom_range(0, 9) != 0);
      acks++;
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset span of 1024
    send_word(1'b0, 32'h1234_5678, 8'h05);   // no start yet: continues from zero
    send_word(1'b1, 32'h0000_0010, 8'h00);   // last sent below span
    send_word(1'b0, 32'h0,         8'hFF);   // full bitmap
    send_word(1'b0, 32'h0,         8'h80);   // empty bitmap still advances
    send_word(1'b0, 32'h0,         8'h7F);   // largest long prefix
    send_word(1'b0, 32'h0,         8'hFF);   // completes it despite the bitmap flag
    send_word(1'b0, 32'h0,         8'h40);   // long prefix left open ...
    send_word(1'b1, 32'hFFFF_FFFF, 8'h3F);   // ... and dropped by the next start
    send_word(1'b0, 32'h0,         8'h7F);   // prefix that wraps the running number
    send_word(1'b0, 32'h0,         8'h00);
    send_word(1'b1, 32'd1024,      8'h81);   // last sent equal to span
    send_word(1'b1, 32'd1025,      8'hC0);   // bitmap flag wins over long flag
    send_word(1'b0, 32'h0,         8'hAA);
    send_word(1'b0, 32'h0,         8'h55);
    send_word(1'b0, 32'h0,         8'h40);
    send_word(1'b1, 32'hAAAA_AAAA, 8'h7F);
    send_word(1'b1, 32'h5555_5555, 8'h01);

    // widest span
    wait_drained();
    write_span(16'hFFFF);
    send_word(1'b1, 32'd65534,     8'h00);
    send_word(1'b1, 32'd65536,     8'h3F);
    send_word(1'b1, 32'hFFFF_FFFF, 8'hFF);

    // narrowest span, bitmap run across the wrap
    wait_drained();
    write_span(16'd1);
    send_word(1'b1, 32'h0,         8'h01);
    send_word(1'b1, 32'hFFFF_FFFF, 8'hFF);
    send_word(1'b0, 32'h0,         8'h3F);
    send_word(1'b1, 32'd1,         8'h80);

    run_phase(12, 81, 16'($urandom_range(1, 65535)));
    run_phase(81, 12, 16'($urandom_range(1, 4096)));
    run_phase(0,  0,  16'($urandom_range(1, 65535)));

    wait_drained();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
